// File: design/letterbox_nearest_scaler_macros.svh
// ----------------------------------------------------------------------------
// letterbox_nearest_scaler_macros.svh
// Assertion macros used by the checker file (lns_chk).
// ----------------------------------------------------------------------------
`ifndef LETTERBOX_NEAREST_SCALER_MACROS_SVH
`define LETTERBOX_NEAREST_SCALER_MACROS_SVH

// same-cycle implication
`define LNS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("letterbox_nearest_scaler check failed");

// next-cycle implication
`define LNS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("letterbox_nearest_scaler check failed");

`endif

// File: design/lns_pkg.sv
// ----------------------------------------------------------------------------
// lns_pkg
// Types, constants and the pixel packing function of the letterbox scaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package lns_pkg;

	localparam int CAPTION_ROWS = 48;
	localparam int DIV_NUM_W    = 22;
	localparam int DIV_DEN_W    = 13;

	typedef enum logic [0:0] {
		CMD_LOAD = 1'b0,
		CMD_DRAW = 1'b1
	} lns_cmd_t;

	typedef enum logic [2:0] {
		CFG_SRC_WIDTH     = 3'd0,
		CFG_SRC_HEIGHT    = 3'd1,
		CFG_SCREEN_WIDTH  = 3'd2,
		CFG_SCREEN_HEIGHT = 3'd3,
		CFG_ROW_PITCH     = 3'd4,
		CFG_BPP           = 3'd5,
		CFG_LAYOUT        = 3'd6,
		CFG_VIEW_ORIGIN   = 3'd7
	} lns_cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DW,
		ST_DW_WAIT,
		ST_DH,
		ST_DH_WAIT,
		ST_CHK,
		ST_SY,
		ST_SY_WAIT,
		ST_SX,
		ST_SX_WAIT,
		ST_IDX,
		ST_PACK,
		ST_DONE
	} lns_state_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} lns_div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quo;
	} lns_div_rsp_t;

	// gray into RGB channels, alpha all ones, trimmed to the pixel size
	function automatic logic [31:0] pack_gray(input logic [7:0] gray,
			input logic [39:0] layout, input logic [2:0] bpp);
		logic [63:0] v;
		logic [63:0] g;
		logic [3:0]  len;
		logic [5:0]  off;
		v = '0;
		for (int c = 0; c < 3; c++) begin
			len = layout[10*c+6 +: 4];
			if (len > 4'd8) len = 4'd8;
			off = layout[10*c +: 6];
			g = {56'd0, gray} >> (4'd8 - len);
			v = v | (g << off);
		end
		len = layout[36 +: 4];
		if (len > 4'd8) len = 4'd8;
		off = layout[30 +: 6];
		if (len != 4'd0) v = v | (((64'd1 << len) - 64'd1) << off);
		case (bpp)
			3'd0:    pack_gray = 32'd0;
			3'd1:    pack_gray = {24'd0, v[7:0]};
			3'd2:    pack_gray = {16'd0, v[15:0]};
			3'd3:    pack_gray = {8'd0, v[23:0]};
			default: pack_gray = v[31:0];
		endcase
	endfunction

endpackage
`default_nettype wire

// File: design/lns_ram.sv
// ----------------------------------------------------------------------------
// lns_ram
// Generic single-port-write, registered-read RAM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lns_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: design/lns_div.sv
// ----------------------------------------------------------------------------
// lns_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lns_div (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire lns_pkg::lns_div_req_t req,
	output lns_pkg::lns_div_rsp_t      rsp
);
	import lns_pkg::*;

	localparam int CNT_W = $clog2(DIV_NUM_W);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W:0]   rem_sh;
	logic [DIV_DEN_W:0]   rem_sub;
	logic                 qbit;

	assign rem_sh  = {rem_q, quo_q[DIV_NUM_W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign qbit    = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_NUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_NUM_W-2:0], qbit};
			rem_q <= qbit ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
endmodule
`default_nettype wire

// File: design/letterbox_nearest_scaler.sv
// ----------------------------------------------------------------------------
// letterbox_nearest_scaler
// Grayscale preview scaler: nearest-neighbor fit with letterbox centering.
// ----------------------------------------------------------------------------
//  channel | handshake          | word
//  in      | in_valid/in_ready  | cmd, src_index, gray_level, out_x, out_y
//  out     | out_valid/out_ready| fb_offset, pixel_word, in_area
//  cfg     | cfg_we             | cfg_index, cfg_data
//
//  A load word is written straight into the image RAM when it is accepted.
//  A draw word runs four divisions in turn on one shared bit-serial divider,
//  then an index and RAM read step and a pack step; an out-of-area word skips
//  the last two divisions, and a word with an invalid source size runs none.
//  Only one draw is in flight; the result register lets the next word enter
//  while the previous result waits on out_ready.
//  Reset clears control and sets config to its defaults; the image RAM is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module letterbox_nearest_scaler #(
	parameter int SRC_MAX_WIDTH  = 256,
	parameter int SRC_MAX_HEIGHT = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        cmd,
	input  wire logic [15:0] src_index,
	input  wire logic [7:0]  gray_level,
	input  wire logic [11:0] out_x,
	input  wire logic [11:0] out_y,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [26:0]      fb_offset,
	output logic [31:0]      pixel_word,
	output logic             in_area,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [39:0] cfg_data
);
	import lns_pkg::*;

	// configuration
	logic [8:0]  src_width_q, src_height_q;
	logic [12:0] screen_width_q;
	logic [11:0] screen_height_q;
	logic [15:0] row_pitch_q;
	logic [2:0]  bpp_cfg_q;
	logic [39:0] layout_q;
	logic [31:0] view_origin_q;

	// working registers
	lns_state_t  state_q, state_d;
	logic [11:0] x_q, y_q;
	logic [12:0] dw_q, dh_q;
	logic [8:0]  sy_q, sx_q;
	logic [26:0] row_q;
	logic        out_valid_q;
	logic [26:0] fb_offset_q;
	logic [31:0] pixel_word_q;
	logic        in_area_q;

	lns_div_req_t div_req;
	lns_div_rsp_t div_rsp;

	logic        ram_we, ram_re;
	logic [15:0] ram_raddr;
	logic [7:0]  ram_rdata;

	logic        accept_in, src_ok, outside, out_free;
	logic [11:0] fit_h;
	logic [2:0]  bpp;
	logic [12:0] dw_clip;
	logic [11:0] half_h;
	logic [12:0] half_w;
	logic [17:0] row_pos, col_pos;
	logic [17:0] idx_full;
	logic [33:0] row_prod;
	logic [20:0] col_prod;

	assign accept_in = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	assign fit_h = (screen_height_q >= 12'(CAPTION_ROWS)) ?
		screen_height_q - 12'(CAPTION_ROWS) : 12'd0;
	assign src_ok = (src_width_q != 9'd0) && (src_height_q != 9'd0) &&
		(32'(src_width_q) <= SRC_MAX_WIDTH) && (32'(src_height_q) <= SRC_MAX_HEIGHT);
	assign bpp = (bpp_cfg_q > 3'd4) ? 3'd4 : bpp_cfg_q;

	// clamp fitted width to the screen
	assign dw_clip = (div_rsp.quo > {9'd0, screen_width_q}) ? screen_width_q :
		div_rsp.quo[12:0];

	assign outside = (dw_q == 13'd0) || (dh_q == 13'd0) ||
		({1'b0, x_q} >= dw_q) || ({1'b0, y_q} >= dh_q);

	// centering margins and framebuffer position (dh <= fit_h, dw <= screen_width)
	assign half_h   = 12'(({1'b0, fit_h} - dh_q) >> 1);
	assign half_w   = (screen_width_q - dw_q) >> 1;
	assign row_pos  = 18'(half_h) + 18'(y_q) + 18'(view_origin_q[31:16]);
	assign col_pos  = 18'(half_w) + 18'(x_q) + 18'(view_origin_q[15:0]);
	assign row_prod = row_pos * row_pitch_q;
	assign col_prod = col_pos * bpp;
	assign idx_full = (sy_q * src_width_q) + 18'(sx_q);

	lns_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	lns_ram #(
		.WIDTH (8),
		.DEPTH (65536)
	) u_image (
		.clk   (clk),
		.we    (ram_we),
		.waddr (src_index),
		.wdata (gray_level),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q     <= 9'd1;
			src_height_q    <= 9'd1;
			screen_width_q  <= 13'd320;
			screen_height_q <= 12'd240;
			row_pitch_q     <= 16'd1280;
			bpp_cfg_q       <= 3'd2;
			layout_q        <= '0;
			view_origin_q   <= '0;
		end else if (cfg_we) begin
			case (lns_cfg_idx_t'(cfg_index))
				CFG_SRC_WIDTH:     src_width_q     <= cfg_data[8:0];
				CFG_SRC_HEIGHT:    src_height_q    <= cfg_data[8:0];
				CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data[12:0];
				CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data[11:0];
				CFG_ROW_PITCH:     row_pitch_q     <= cfg_data[15:0];
				CFG_BPP:           bpp_cfg_q       <= cfg_data[2:0];
				CFG_LAYOUT:        layout_q        <= cfg_data;
				CFG_VIEW_ORIGIN:   view_origin_q   <= cfg_data[31:0];
				default:           ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (accept_in && lns_cmd_t'(cmd) == CMD_DRAW) state_d = ST_DW;
			ST_DW:      state_d = src_ok ? ST_DW_WAIT : ST_CHK;
			ST_DW_WAIT: if (div_rsp.done) state_d = ST_DH;
			ST_DH:      state_d = ST_DH_WAIT;
			ST_DH_WAIT: if (div_rsp.done) state_d = ST_CHK;
			ST_CHK:     state_d = outside ? ST_DONE : ST_SY;
			ST_SY:      state_d = ST_SY_WAIT;
			ST_SY_WAIT: if (div_rsp.done) state_d = ST_SX;
			ST_SX:      state_d = ST_SX_WAIT;
			ST_SX_WAIT: if (div_rsp.done) state_d = ST_IDX;
			ST_IDX:     state_d = ST_PACK;
			ST_PACK:    state_d = ST_DONE;
			ST_DONE:    if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// control outputs: handshake, divider requests, RAM strobes
	always_comb begin
		in_ready      = (state_q == ST_IDLE);
		ram_we        = 1'b0;
		ram_re        = 1'b0;
		ram_raddr     = idx_full[15:0];
		div_req.start = 1'b0;
		div_req.num   = '0;
		div_req.den   = '0;
		case (state_q)
			ST_IDLE: ram_we = accept_in && (lns_cmd_t'(cmd) == CMD_LOAD);
			ST_DW: begin
				div_req.start = src_ok;
				div_req.num   = DIV_NUM_W'(src_width_q) * DIV_NUM_W'(fit_h);
				div_req.den   = 13'(src_height_q);
			end
			ST_DH: begin
				div_req.start = 1'b1;
				div_req.num   = DIV_NUM_W'(src_height_q) * DIV_NUM_W'(dw_q);
				div_req.den   = 13'(src_width_q);
			end
			ST_SY: begin
				div_req.start = 1'b1;
				div_req.num   = DIV_NUM_W'(y_q) * DIV_NUM_W'(src_height_q);
				div_req.den   = dh_q;
			end
			ST_SX: begin
				div_req.start = 1'b1;
				div_req.num   = DIV_NUM_W'(x_q) * DIV_NUM_W'(src_width_q);
				div_req.den   = dw_q;
			end
			ST_IDX:  ram_re = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept_in) begin
					x_q <= out_x;
					y_q <= out_y;
				end
			end
			ST_DW: begin
				if (!src_ok) begin
					dw_q <= '0;
					dh_q <= '0;
				end
			end
			ST_DW_WAIT: if (div_rsp.done) dw_q <= dw_clip;
			ST_DH_WAIT: if (div_rsp.done) dh_q <= div_rsp.quo[12:0];
			ST_CHK: begin
				// out-of-area result is all zero
				fb_offset_q  <= '0;
				pixel_word_q <= '0;
				in_area_q    <= 1'b0;
			end
			ST_SY_WAIT: if (div_rsp.done) sy_q <= div_rsp.quo[8:0];
			ST_SX_WAIT: if (div_rsp.done) sx_q <= div_rsp.quo[8:0];
			ST_IDX:     row_q <= row_prod[26:0];
			ST_PACK: begin
				fb_offset_q  <= row_q + 27'(col_prod);
				pixel_word_q <= pack_gray(ram_rdata, layout_q, bpp);
				in_area_q    <= 1'b1;
			end
			ST_DONE: begin
				if (out_free) begin
					fb_offset    <= fb_offset_q;
					pixel_word   <= pixel_word_q;
					in_area      <= in_area_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

// File: design/lns_chk.sv
// ----------------------------------------------------------------------------
// lns_chk
// Port-level checks for the letterbox scaler, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "letterbox_nearest_scaler_macros.svh"
module lns_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        cmd,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [26:0] fb_offset,
	input wire logic [31:0] pixel_word,
	input wire logic        in_area
);
	import lns_pkg::*;

	// a stalled result holds
	`LNS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(fb_offset) && $stable(pixel_word) && $stable(in_area))
	// an out-of-area result carries no offset and no pixel
	`LNS_ASSERT_NOW(a_outside_zero, clk, arst_n, out_valid && !in_area, fb_offset == 27'd0 && pixel_word == 32'd0)
	// a draw keeps the input closed while it runs
	`LNS_ASSERT_NEXT(a_draw_busy, clk, arst_n, in_valid && in_ready && cmd == CMD_DRAW, !in_ready)
	// a load finishes in its own cycle
	`LNS_ASSERT_NEXT(a_load_quick, clk, arst_n, in_valid && in_ready && cmd == CMD_LOAD, in_ready)
endmodule

bind letterbox_nearest_scaler lns_chk u_lns_chk (.*);
`default_nettype wire
